// ===== hw/rtl/breg_pkg.sv =====
// Shared types and constants for the Exp-Golomb bit reader.
// Used by breg_fetch and bit_reader_exp_golomb_core; depends on nothing.
package breg_pkg;

  // operation codes, carried on in_tuser
  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_PEEK    = 3'd2;
  localparam logic [2:0] OP_UE      = 3'd3;
  localparam logic [2:0] OP_SE      = 3'd4;
  localparam logic [2:0] OP_ALIGN   = 3'd5;
  localparam logic [2:0] OP_FIND    = 3'd6;
  localparam logic [2:0] OP_RESTART = 3'd7;

  localparam int          OFS_W    = 16;
  localparam logic [15:0] OFS_MAX  = 16'hFFFF;
  localparam logic [4:0]  MAX_BITS = 5'd25;

  // byte index: bit offset / 8 plus up to eight window slots
  localparam int IDX_W  = 14;
  localparam int SLOT_W = 4;
  // window register: nine bytes
  localparam int WIN_W  = 72;

  localparam logic [SLOT_W-1:0] SLOT_FIRST   = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_WORD_LO = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_UE_LO   = 4'd8;

  typedef struct packed {
    logic              start;
    logic [IDX_W-1:0]  base;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] last;
  } fetch_req_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
  } fetch_cap_t;

  // leading zeros of a nonzero byte
  function automatic logic [2:0] lzc8(input logic [7:0] b);
    logic [2:0] r;
    priority casez (b)
      8'b1???_????: r = 3'd0;
      8'b01??_????: r = 3'd1;
      8'b001?_????: r = 3'd2;
      8'b0001_????: r = 3'd3;
      8'b0000_1???: r = 3'd4;
      8'b0000_01??: r = 3'd5;
      8'b0000_001?: r = 3'd6;
      default:      r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/breg_byte_mem.sv =====
// Byte store of the bit reader: one write port, one read port, registered read.
// No package dependencies.
module breg_byte_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/breg_fetch.sv =====
// Window fetch sequencer: issues one byte read per cycle into the byte store
// and returns the bytes tagged with their window slot. Uses breg_pkg.
module breg_fetch #(
  parameter int CNT_W  = 13,
  parameter int ADDR_W = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  breg_pkg::fetch_req_t req,
  input  logic [CNT_W-1:0]     byte_cnt,
  output logic                 rd_en,
  output logic [ADDR_W-1:0]    rd_addr,
  input  logic [7:0]           rd_data,
  output breg_pkg::fetch_cap_t cap
);

  localparam int CMP_W = (CNT_W > breg_pkg::IDX_W) ? CNT_W : breg_pkg::IDX_W;

  logic                          busy_r, busy_nxt;
  logic                          pend_r;
  logic [breg_pkg::IDX_W-1:0]    idx_r;
  logic [breg_pkg::SLOT_W-1:0]   slot_r, last_r, pend_slot_r;
  logic                          pend_last_r, pend_zero_r;
  logic                          in_range;

  // bytes past the stored count read as zero
  assign in_range = CMP_W'(idx_r) < CMP_W'(byte_cnt);
  assign busy_nxt = req.start | (busy_r & (slot_r != last_r));
  assign rd_en    = busy_r & in_range;
  assign rd_addr  = ADDR_W'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      idx_r  <= req.base + breg_pkg::IDX_W'(req.first);
      slot_r <= req.first;
      last_r <= req.last;
    end else if (busy_r) begin
      idx_r  <= idx_r + 1'b1;
      slot_r <= slot_r + 1'b1;
    end
    pend_slot_r <= slot_r;
    pend_last_r <= (slot_r == last_r);
    pend_zero_r <= ~in_range;
  end

  assign cap.valid = pend_r;
  assign cap.last  = pend_last_r;
  assign cap.slot  = pend_slot_r;
  assign cap.data  = pend_zero_r ? 8'd0 : rd_data;

endmodule

// ===== hw/rtl/bit_reader_exp_golomb_core.sv =====
// Top level of the MSB-first bit reader with Exp-Golomb decoding.
// Uses breg_pkg, breg_byte_mem and breg_fetch.
//
// MSB-first bit reader over a byte store of BUF_BYTES bytes. Each input item
// gives exactly one result item. The operation code travels on in_tuser; load
// appends a byte, read/peek return up to 25 bits at the bit offset, ue/se
// decode an Exp-Golomb code, align skips to the next byte boundary, find
// searches bytewise for a bit pattern, restart returns to bit zero. Bits past
// the stored bytes read as zero. One item is worked on at a time; the
// result sits in an output register so the next item is taken while it waits.
// With the output free, the steps per item are: load writes a byte or flags a
// full store; align and restart only move the offset; read and peek make four
// byte reads from the single read port of the store, then align and extract;
// ue makes nine byte reads, then takes the zero prefix one byte at a time,
// and se adds a sign step; find stops at once when no position is left to
// test, otherwise reads four bytes for the first position and one new byte
// for each further byte position. The store needs no clearing after reset.
module bit_reader_exp_golomb_core #(
  parameter int BUF_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_byte[7:0], bit_count[12:8], pattern[37:13]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // value[31:0], signed_value[63:32], found[64],
                                  // remaining_bytes[77:65], error[78]
);

  localparam int CNT_W  = $clog2(BUF_BYTES + 1);
  localparam int ADDR_W = $clog2(BUF_BYTES);
  localparam int REM_W  = (CNT_W > 13) ? CNT_W : 13;
  localparam int WIN_W  = breg_pkg::WIN_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD    = 4'd1;
  localparam logic [3:0] S_FETCH   = 4'd2;
  localparam logic [3:0] S_WALIGN  = 4'd3;
  localparam logic [3:0] S_EXTRACT = 4'd4;
  localparam logic [3:0] S_LZ      = 4'd5;
  localparam logic [3:0] S_UEFIN   = 4'd6;
  localparam logic [3:0] S_SEVAL   = 4'd7;
  localparam logic [3:0] S_FCHK    = 4'd8;
  localparam logic [3:0] S_FALIGN  = 4'd9;
  localparam logic [3:0] S_FCMP    = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  // saturating advance of the bit offset
  function automatic logic [15:0] sat_add(input logic [15:0] ofs, input logic [5:0] k);
    logic [16:0] t;
    t = {1'b0, ofs} + 17'(k);
    return t[16] ? breg_pkg::OFS_MAX : t[15:0];
  endfunction

  // ---------------------------------------------------------------- state
  logic [3:0]       state_r, state_nxt;
  logic [15:0]      ofs_r, ofs_nxt;
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [79:0]      out_data_r, out_data_nxt;

  // item fields held for the whole operation
  logic [2:0]  op_r, op_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [24:0] pat_r, pat_nxt;

  // working registers
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [31:0]      cmp_r, cmp_nxt;
  logic [4:0]       z_r, z_nxt;
  logic             first_r, first_nxt;
  logic [31:0]      res_value_r, res_value_nxt;
  logic [31:0]      res_sval_r, res_sval_nxt;
  logic             res_found_r, res_found_nxt;
  logic             res_err_r, res_err_nxt;

  // ---------------------------------------------------------------- store
  breg_pkg::fetch_req_t fetch_req;
  breg_pkg::fetch_cap_t cap;
  logic                 mem_we;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [7:0]           mem_rdata;

  // loads write only in S_LOAD and window reads happen only in S_FETCH, so
  // the single store never sees a read and write to the same entry at once
  breg_byte_mem #(
    .DEPTH  (BUF_BYTES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (ADDR_W'(byte_cnt_r)),
    .wr_data (data_r),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  breg_fetch #(
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (fetch_req),
    .byte_cnt (byte_cnt_r),
    .rd_en    (mem_re),
    .rd_addr  (mem_raddr),
    .rd_data  (mem_rdata),
    .cap      (cap)
  );

  // ---------------------------------------------------------------- helpers
  logic                       acc;
  logic [2:0]                 frac;
  logic [breg_pkg::IDX_W-1:0] base_idx;
  logic [REM_W-1:0]           rem_full;
  logic [4:0]                 in_n;
  logic [31:0]                ext_val;   // top n bits of the window
  logic [31:0]                fnd_val;   // top n bits of the find compare word
  logic [4:0]                 n_shift;
  logic [7:0]                 top8;
  logic [2:0]                 lz;
  logic [31:0]                ue_p1;     // code number plus one
  logic [32:0]                se_half;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid & in_tready;
  assign frac      = ofs_r[2:0];
  assign base_idx  = breg_pkg::IDX_W'(ofs_r[15:3]);
  assign rem_full  = (REM_W'(byte_cnt_r) > REM_W'(ofs_r[15:3])) ?
                     REM_W'(byte_cnt_r) - REM_W'(ofs_r[15:3]) : '0;
  assign in_n      = (in_tdata[12:8] > breg_pkg::MAX_BITS) ? breg_pkg::MAX_BITS
                                                           : in_tdata[12:8];
  assign n_shift   = 5'(6'd32 - {1'b0, n_r});
  assign ext_val   = (n_r == 5'd0) ? 32'd0 : (win_r[WIN_W-1 -: 32] >> n_shift);
  assign fnd_val   = (n_r == 5'd0) ? 32'd0 : (cmp_r >> n_shift);
  assign top8      = win_r[WIN_W-1 -: 8];
  assign lz        = breg_pkg::lzc8(top8);
  assign ue_p1     = win_r[WIN_W-1 -: 32] >> (5'd31 - z_r);
  assign se_half   = ({1'b0, res_value_r} + 33'd1) >> 1;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    ofs_nxt       = ofs_r;
    byte_cnt_nxt  = byte_cnt_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    data_nxt      = data_r;
    n_nxt         = n_r;
    pat_nxt       = pat_r;
    win_nxt       = win_r;
    cmp_nxt       = cmp_r;
    z_nxt         = z_r;
    first_nxt     = first_r;
    res_value_nxt = res_value_r;
    res_sval_nxt  = res_sval_r;
    res_found_nxt = res_found_r;
    res_err_nxt   = res_err_r;
    mem_we        = 1'b0;
    fetch_req     = '0;

    // fetched bytes land in their window slot
    if (cap.valid) begin
      win_nxt[(WIN_W-1) - 8*int'(cap.slot) -: 8] = cap.data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt        = in_tuser;
          data_nxt      = in_tdata[7:0];
          n_nxt         = in_n;
          pat_nxt       = in_tdata[37:13];
          first_nxt     = 1'b1;
          res_value_nxt = '0;
          res_sval_nxt  = '0;
          res_found_nxt = 1'b0;
          res_err_nxt   = 1'b0;
          unique case (in_tuser)
            breg_pkg::OP_LOAD: state_nxt = S_LOAD;
            breg_pkg::OP_READ, breg_pkg::OP_PEEK: begin
              fetch_req.start = 1'b1;
              fetch_req.base  = base_idx;
              fetch_req.first = breg_pkg::SLOT_FIRST;
              fetch_req.last  = breg_pkg::SLOT_WORD_LO;
              state_nxt       = S_FETCH;
            end
            breg_pkg::OP_UE, breg_pkg::OP_SE: begin
              fetch_req.start = 1'b1;
              fetch_req.base  = base_idx;
              fetch_req.first = breg_pkg::SLOT_FIRST;
              fetch_req.last  = breg_pkg::SLOT_UE_LO;
              state_nxt       = S_FETCH;
            end
            breg_pkg::OP_ALIGN: begin
              if (frac != 3'd0) begin
                ofs_nxt = sat_add(ofs_r, 6'(4'd8 - {1'b0, frac}));
              end
              state_nxt = S_DONE;
            end
            breg_pkg::OP_FIND: state_nxt = S_FCHK;
            default: begin
              ofs_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_LOAD: begin
        if (byte_cnt_r < CNT_W'(BUF_BYTES)) begin
          mem_we       = 1'b1;
          byte_cnt_nxt = byte_cnt_r + 1'b1;
        end else begin
          res_err_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_FETCH: begin
        if (cap.valid && cap.last) begin
          state_nxt = (op_r == breg_pkg::OP_FIND) ? S_FALIGN : S_WALIGN;
        end
      end

      S_WALIGN: begin
        win_nxt   = win_r << frac;
        z_nxt     = '0;
        state_nxt = (op_r == breg_pkg::OP_READ || op_r == breg_pkg::OP_PEEK) ?
                    S_EXTRACT : S_LZ;
      end

      S_EXTRACT: begin
        res_value_nxt = ext_val;
        if (op_r == breg_pkg::OP_READ) begin
          ofs_nxt = sat_add(ofs_r, {1'b0, n_r});
        end
        state_nxt = S_DONE;
      end

      // one byte of the zero prefix per cycle
      S_LZ: begin
        if (top8 == 8'd0) begin
          if (z_r == 5'd24) begin
            res_err_nxt = 1'b1;   // 32 zeros: no code, offset stays
            state_nxt   = S_DONE;
          end else begin
            z_nxt   = z_r + 5'd8;
            win_nxt = win_r << 8;
          end
        end else begin
          z_nxt     = z_r + 5'(lz);
          win_nxt   = win_r << lz;   // leading one now at the top
          state_nxt = S_UEFIN;
        end
      end

      S_UEFIN: begin
        res_value_nxt = ue_p1 - 32'd1;
        ofs_nxt       = sat_add(ofs_r, {z_r, 1'b1});
        state_nxt     = (op_r == breg_pkg::OP_SE) ? S_SEVAL : S_DONE;
      end

      S_SEVAL: begin
        if (res_value_r[0]) begin
          res_sval_nxt = (se_half > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : se_half[31:0];
        end else begin
          res_sval_nxt = 32'd0 - (res_value_r >> 1);
        end
        state_nxt = S_DONE;
      end

      S_FCHK: begin
        if (rem_full > REM_W'(n_r >> 3)) begin
          fetch_req.start = 1'b1;
          fetch_req.base  = base_idx;
          // later steps slide the window by one byte and read only the new one
          fetch_req.first = first_r ? breg_pkg::SLOT_FIRST : breg_pkg::SLOT_WORD_LO;
          fetch_req.last  = breg_pkg::SLOT_WORD_LO;
          state_nxt       = S_FETCH;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FALIGN: begin
        cmp_nxt   = 32'(win_r[WIN_W-1 -: 32] << frac);
        state_nxt = S_FCMP;
      end

      S_FCMP: begin
        if (fnd_val == {7'd0, pat_r}) begin
          res_found_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else if (ofs_r > (breg_pkg::OFS_MAX - 16'd8)) begin
          state_nxt = S_DONE;
        end else begin
          ofs_nxt   = ofs_r + 16'd8;
          win_nxt   = win_r << 8;
          first_nxt = 1'b0;
          state_nxt = S_FCHK;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {1'b0, res_err_r, rem_full[12:0], res_found_r,
                           res_sval_r, res_value_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ofs_r       <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ofs_r       <= ofs_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    op_r        <= op_nxt;
    data_r      <= data_nxt;
    n_r         <= n_nxt;
    pat_r       <= pat_nxt;
    win_r       <= win_nxt;
    cmp_r       <= cmp_nxt;
    z_r         <= z_nxt;
    first_r     <= first_nxt;
    res_value_r <= res_value_nxt;
    res_sval_r  <= res_sval_nxt;
    res_found_r <= res_found_nxt;
    res_err_r   <= res_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_cap_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    cap.valid |-> (state_r == S_FETCH))
    else $error("byte capture outside fetch state");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CNT_W'(BUF_BYTES))
    else $error("byte count beyond store size");

  a_err_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_err_r) |->
      (op_r == breg_pkg::OP_LOAD || op_r == breg_pkg::OP_UE || op_r == breg_pkg::OP_SE))
    else $error("error flag on an operation that cannot fail");

  a_found_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_found_r) |-> (op_r == breg_pkg::OP_FIND))
    else $error("found flag outside find");

  a_ofs_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> $stable(ofs_r))
    else $error("load moved the bit offset");
`endif

endmodule

// ===== sim/tb_bit_reader_exp_golomb_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bit_reader_exp_golomb_core: sends op items on the
// input stream, predicts each result with a behavioral bit reader and checks
// the output stream field by field. Depends on breg_pkg and the core RTL.
module tb_bit_reader_exp_golomb_core;

  localparam int BUF_BYTES    = 4096;
  localparam int IDLE_PCT     = 19;      // idle cycles per hundred, both sides
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int STALL_LIMIT  = 100000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 550;
  localparam int unsigned OFS_TOP  = 32'(breg_pkg::OFS_MAX);
  localparam int unsigned BITS_TOP = 32'(breg_pkg::MAX_BITS);

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] signed_value;
    logic        found;
    logic [12:0] remaining;
    logic        error;
  } reader_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;                // data_byte[7:0], bit_count[12:8],
                                               // pattern[37:13]
  logic [2:0]  in_tuser   = breg_pkg::OP_LOAD; // op[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;            // value[31:0], signed_value[63:32], found[64],
                                     // remaining_bytes[77:65], error[78]

  bit          no_idle      = 1'b0;  // set for a stretch with no idling on either side
  bit          rx_hold      = 1'b0;  // receiver hold-off in progress
  event        hold_rx;
  int unsigned fail_count   = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_sent   = 0;

  // behavioral copy of the reader state
  logic [7:0]     stream_mem [BUF_BYTES];
  int unsigned    bit_pos    = 0;
  int unsigned    byte_total = 0;
  reader_result_t expected_q[$];

  bit_reader_exp_golomb_core #(.BUF_BYTES(BUF_BYTES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // bits past the stored bytes read as zero
  function automatic logic stream_bit(int unsigned pos);
    int unsigned idx;
    idx = pos >> 3;
    if (idx >= byte_total) return 1'b0;
    return stream_mem[idx][7 - (pos & 7)];
  endfunction

  function automatic logic [31:0] stream_bits(int unsigned pos, int unsigned n);
    logic [31:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < n && i < 32; i++) v = {v[30:0], stream_bit(pos + i)};
    return v;
  endfunction

  // offset saturates instead of wrapping
  function automatic void move_bit_pos(int unsigned k);
    bit_pos = (bit_pos + k > OFS_TOP) ? OFS_TOP : bit_pos + k;
  endfunction

  function automatic int unsigned bytes_left();
    return (byte_total > (bit_pos >> 3)) ? byte_total - (bit_pos >> 3) : 0;
  endfunction

  function automatic int unsigned clamp_count(logic [4:0] count);
    return (32'(count) > BITS_TOP) ? BITS_TOP : 32'(count);
  endfunction

  // Exp-Golomb code number at the offset; a prefix of 32 zeros is an error
  // and leaves the offset where it is.
  function automatic logic decode_code(output logic [31:0] code);
    int unsigned zeros;
    logic [31:0] lead_one;
    zeros = 0;
    code  = '0;
    while (zeros < 32 && !stream_bit(bit_pos + zeros)) zeros++;
    if (zeros >= 32) return 1'b0;
    lead_one = 32'd1 << zeros;
    code = (lead_one | stream_bits(bit_pos + zeros + 1, zeros)) - 32'd1;
    move_bit_pos(2 * zeros + 1);
    return 1'b1;
  endfunction

  function automatic void predict_item(logic [2:0] op, logic [7:0] data,
                                       logic [4:0] count, logic [24:0] pat);
    reader_result_t r;
    logic [31:0] code;
    logic [32:0] half;
    int unsigned n;
    r = '0;
    n = clamp_count(count);
    case (op)
      breg_pkg::OP_LOAD: begin
        if (byte_total < BUF_BYTES) begin
          stream_mem[byte_total] = data;
          byte_total++;
        end else begin
          r.error = 1'b1;
        end
      end
      breg_pkg::OP_READ: begin
        r.value = stream_bits(bit_pos, n);
        move_bit_pos(n);
      end
      breg_pkg::OP_PEEK: r.value = stream_bits(bit_pos, n);
      breg_pkg::OP_UE: begin
        if (decode_code(code)) r.value = code;
        else r.error = 1'b1;
      end
      breg_pkg::OP_SE: begin
        if (decode_code(code)) begin
          r.value = code;
          // odd codes map to positive values, even ones to zero or negative
          if (code[0]) begin
            half = ({1'b0, code} + 33'd1) >> 1;
            r.signed_value = (half > 33'h07FFFFFFF) ? 32'h7FFFFFFF : half[31:0];
          end else begin
            r.signed_value = 32'd0 - (code >> 1);
          end
        end else begin
          r.error = 1'b1;
        end
      end
      breg_pkg::OP_ALIGN: if (bit_pos % 8 != 0) move_bit_pos(8 - bit_pos % 8);
      breg_pkg::OP_FIND: begin
        // bytewise scan; stops on a match, at the end of data or before saturating
        while (bytes_left() > (n >> 3)) begin
          if (stream_bits(bit_pos, n) == {7'd0, pat}) begin
            r.found = 1'b1;
            break;
          end
          if (bit_pos + 8 > OFS_TOP) break;
          bit_pos += 8;
        end
      end
      breg_pkg::OP_RESTART: bit_pos = 0;
    endcase
    r.remaining = 13'(bytes_left());
    expected_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_item(input logic [2:0] op, input logic [7:0] data = 8'd0,
                           input logic [4:0] count = 5'd0, input logic [24:0] pat = 25'd0);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, pat, count, data};
    do @(posedge clk); while (!in_tready);
    predict_item(op, data, count, pat);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Any op with random fields; finds often get a pattern lifted from the
  // stream a few bytes ahead so that some of them hit.
  task automatic send_noise_item();
    logic [2:0]  op;
    logic [4:0]  count;
    logic [24:0] pat;
    count = 5'($urandom_range(31));
    op    = ($urandom_range(29) == 0) ? breg_pkg::OP_RESTART :
            3'($urandom_range(breg_pkg::OP_FIND, breg_pkg::OP_LOAD));
    pat   = 25'($urandom());
    if (op == breg_pkg::OP_FIND && $urandom_range(1))
      pat = 25'(stream_bits(bit_pos + 8 * $urandom_range(6), clamp_count(count)));
    send_item(op, 8'($urandom()), count, pat);
  endtask

  // Loads a start code followed by random Exp-Golomb codes, then syncs on the
  // start code and decodes them as ue or se. Now and then the run is cut short.
  task automatic send_coded_run();
    logic        bits_q[$];
    logic [7:0]  b;
    logic [32:0] x;
    logic [31:0] code;
    int          i;
    int          lead;
    int unsigned width;
    int unsigned n_codes;
    // past the end nothing is found, so go back to the top first
    if (bytes_left() == 0) send_item(breg_pkg::OP_RESTART);
    n_codes = $urandom_range(6, 1);
    for (i = 23; i >= 0; i--) bits_q.push_back(i == 0);
    repeat (n_codes) begin
      width = ($urandom_range(15) == 0) ? $urandom_range(31) : $urandom_range(12);
      code  = $urandom() & ((32'd1 << width) - 32'd1);
      x     = {1'b0, code} + 33'd1;
      lead  = 32;
      while (!x[lead]) lead--;
      repeat (lead) bits_q.push_back(1'b0);
      for (i = lead; i >= 0; i--) bits_q.push_back(x[i]);
    end
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(bits_q.size() - 24)) void'(bits_q.pop_back());
    while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(1)));
    while (bits_q.size() != 0) begin
      b = '0;
      repeat (8) b = {b[6:0], bits_q.pop_front()};
      send_item(breg_pkg::OP_LOAD, b);
    end
    send_item(breg_pkg::OP_FIND, 8'd0, 5'd24, 25'h000001);
    send_item(breg_pkg::OP_READ, 8'd0, 5'd24);
    repeat (n_codes) begin
      if ($urandom_range(5) == 0)
        send_item(breg_pkg::OP_PEEK, 8'd0, 5'($urandom_range(31)));
      send_item($urandom_range(1) ? breg_pkg::OP_SE : breg_pkg::OP_UE);
    end
    send_item(breg_pkg::OP_ALIGN);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_item(breg_pkg::OP_UE);                      // empty store: 32 zeros, error
    send_item(breg_pkg::OP_READ, 8'd0, 5'd31);       // zeros; count clamps to 25
    send_item(breg_pkg::OP_ALIGN);                   // 25 -> 32
    send_item(breg_pkg::OP_RESTART);
    // 31 zeros, a one, then 31 suffix bits: the longest legal code
    send_item(breg_pkg::OP_LOAD, 8'h00);
    send_item(breg_pkg::OP_LOAD, 8'h00);
    send_item(breg_pkg::OP_LOAD, 8'h00);
    send_item(breg_pkg::OP_LOAD, 8'h01);
    send_item(breg_pkg::OP_LOAD, 8'hFF);
    send_item(breg_pkg::OP_LOAD, 8'hFF);
    send_item(breg_pkg::OP_LOAD, 8'hFF);
    send_item(breg_pkg::OP_LOAD, 8'hFD);
    send_item(breg_pkg::OP_PEEK, 8'd0, 5'd0);
    send_item(breg_pkg::OP_PEEK, 8'd0, 5'd25);
    send_item(breg_pkg::OP_SE);                      // largest positive se value
    send_item(breg_pkg::OP_RESTART);
    send_item(breg_pkg::OP_UE);
    send_item(breg_pkg::OP_ALIGN);                   // unaligned
    send_item(breg_pkg::OP_ALIGN);                   // already aligned
    send_item(breg_pkg::OP_RESTART);
    send_item(breg_pkg::OP_FIND, 8'd0, 5'd0, 25'd0); // zero-width match at once
    send_item(breg_pkg::OP_FIND, 8'd0, 5'd24, 25'h1000000); // pattern wider than count
    send_item(breg_pkg::OP_RESTART);
    send_item(breg_pkg::OP_FIND, 8'd0, 5'd8, 25'h0000FF);
    send_item(breg_pkg::OP_READ, 8'd0, 5'd8);
    send_item(breg_pkg::OP_SE);                      // shortest code, a lone one bit: value zero
  endtask

  task automatic test_random_streams();
    int unsigned first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      // a stretch in the middle runs with no idling at all
      no_idle <= (items_sent - first >= 250) && (items_sent - first < 350);
      if ($urandom_range(3) != 0) send_coded_run();
      else repeat ($urandom_range(8, 1)) send_noise_item();
    end
    no_idle <= 1'b0;
  endtask

  // receiver stalls long enough for the core to back up into its input,
  // then the sender waits for everything to come out
  task automatic test_backpressure();
    -> hold_rx;
    repeat (24) send_noise_item();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n || rx_hold) out_tready <= 1'b0;
    else out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  initial forever begin
    @(hold_rx);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    reader_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("value", want.value, out_tdata[31:0]);
        check_field("signed_value", want.signed_value, out_tdata[63:32]);
        check_field("found", 32'(want.found), 32'(out_tdata[64]));
        check_field("remaining_bytes", 32'(want.remaining), 32'(out_tdata[77:65]));
        check_field("error", 32'(want.error), 32'(out_tdata[78]));
      end
    end
  end

  // watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL bit_reader_exp_golomb_core");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_streams();
    test_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("PASS bit_reader_exp_golomb_core");
    end else begin
      $display("FAIL bit_reader_exp_golomb_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/breg_pkg.sv
hw/rtl/breg_byte_mem.sv
hw/rtl/breg_fetch.sv
hw/rtl/bit_reader_exp_golomb_core.sv
sim/tb_bit_reader_exp_golomb_core.sv
